[design/fbe_pkg.sv]
// Shared types and constants for the FEC error rate estimator.
`timescale 1ns / 1ps

package fbe_pkg;

  localparam int CNT_W    = 64;   // codeword counter width
  localparam int PER_W    = 32;   // period width
  localparam int TICK_W   = 10;   // tick rate register width
  localparam int KC_W     = 30;   // tick * 10^6 fits here
  localparam int KU_W     = 50;   // tick * 10^12 fits here
  localparam int MUL_STEPS = KU_W;  // one multiplier bit per cycle
  localparam int DIV_STEPS = CNT_W; // one quotient bit per cycle
  localparam int BCD_DIGITS = 20;   // 2^64-1 has 20 decimal digits
  localparam int BCD_W    = 4 * BCD_DIGITS;
  localparam int MANT_W   = 10;
  localparam int EXP_W    = 5;
  localparam int STAT_W   = 3;

  localparam logic [TICK_W-1:0] TICK_RESET = 10'd250;
  localparam logic [CNT_W-1:0]  CW_BITS    = 64'd5440;
  localparam logic [KC_W-1:0]   CCW_MULT   = 30'd1000000;
  localparam logic [KU_W-1:0]   UCW_MULT   = 50'd1000000000000;
  localparam logic [EXP_W-1:0]  CCW_EXP    = 5'd6;
  localparam logic [EXP_W-1:0]  UCW_EXP    = 5'd12;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_ZERO_TOTAL = 3'd1,
    ST_CCW_OVF    = 3'd2,
    ST_UCW_OVF    = 3'd3,
    ST_ZERO_DIV   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_CHECK,
    S_DIV,
    S_NORM,
    S_DONE
  } state_t;

endpackage

[design/fec_ber_estimate.sv]
// FEC corrected and uncorrectable codeword error rate estimator, bit serial.
`timescale 1ns / 1ps
// Sequence: prep, 50-step multiply, check, then a 64-step divide and a normalize for the
//   corrected rate and again for the uncorrectable rate, then done; an error status found at the check skips to done.
// A new word is accepted only in idle, once the previous result has entered the output
//   register; that transfer waits while the output register still holds an untaken result.
// Reset (rst_n low, synchronous): controller idle, no result pending, tick_rate = 250.
module fec_ber_estimate (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [fbe_pkg::TICK_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [fbe_pkg::CNT_W-1:0]   in_uncorrectable_count,
  input  logic [fbe_pkg::CNT_W-1:0]   in_corrected_count,
  input  logic [fbe_pkg::CNT_W-1:0]   in_good_count,
  input  logic [fbe_pkg::PER_W-1:0]   in_period_length,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fbe_pkg::STAT_W-1:0]  out_status,
  output logic [fbe_pkg::MANT_W-1:0]  out_corrected_mantissa,
  output logic signed [fbe_pkg::EXP_W-1:0] out_corrected_exponent,
  output logic [fbe_pkg::MANT_W-1:0]  out_uncorrectable_mantissa,
  output logic signed [fbe_pkg::EXP_W-1:0] out_uncorrectable_exponent
);
  import fbe_pkg::*;

  localparam int ACC_C_W = CNT_W + KC_W;  // full corrected numerator
  localparam int ACC_U_W = CNT_W + KU_W;  // full uncorrectable numerator

  // Control
  state_t           state_r, state_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             sel_r, sel_nxt;       // 0: corrected rate, 1: uncorrectable rate
  logic [TICK_W-1:0] tick_r, tick_nxt;

  // Captured word
  logic [CNT_W-1:0] ucw_r, ucw_nxt;
  logic [CNT_W-1:0] ccw_r, ccw_nxt;
  logic [CNT_W-1:0] gcw_r, gcw_nxt;

  // Multiply phase: three Horner accumulators fed MSB first from shift registers
  logic [MUL_STEPS-1:0] p_sr_r, p_sr_nxt;
  logic [MUL_STEPS-1:0] kc_sr_r, kc_sr_nxt;
  logic [MUL_STEPS-1:0] ku_sr_r, ku_sr_nxt;
  logic [CNT_W-1:0]     t_r, t_nxt;        // corrected + good * 5440, wrapped
  logic                 zero_r, zero_nxt;  // corrected + good wrapped to zero
  logic [ACC_C_W-1:0]   acc_c_r, acc_c_nxt;
  logic [ACC_U_W-1:0]   acc_u_r, acc_u_nxt;
  logic [CNT_W-1:0]     den_r, den_nxt;

  // Divide / decimal conversion
  logic [CNT_W-1:0]   num_sr_r, num_sr_nxt;
  logic [CNT_W:0]     rem_r, rem_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [EXP_W-1:0]   mag_r, mag_nxt;

  // Result
  status_t            status_r, status_nxt;
  logic [MANT_W-1:0]  cm_r, cm_nxt, um_r, um_nxt;
  logic [EXP_W-1:0]   ce_r, ce_nxt, ue_r, ue_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [MANT_W-1:0]  out_cm_r, out_cm_nxt, out_um_r, out_um_nxt;
  logic [EXP_W-1:0]   out_ce_r, out_ce_nxt, out_ue_r, out_ue_nxt;

  // Datapath helpers
  logic [CNT_W:0]   div_shift;
  logic [CNT_W:0]   div_diff;
  logic             div_ge;
  logic [BCD_W-1:0] bcd_adj;
  logic [MANT_W-1:0] mant;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      tick_r      <= TICK_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      tick_r      <= tick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    sel_r        <= sel_nxt;
    ucw_r        <= ucw_nxt;
    ccw_r        <= ccw_nxt;
    gcw_r        <= gcw_nxt;
    p_sr_r       <= p_sr_nxt;
    kc_sr_r      <= kc_sr_nxt;
    ku_sr_r      <= ku_sr_nxt;
    t_r          <= t_nxt;
    zero_r       <= zero_nxt;
    acc_c_r      <= acc_c_nxt;
    acc_u_r      <= acc_u_nxt;
    den_r        <= den_nxt;
    num_sr_r     <= num_sr_nxt;
    rem_r        <= rem_nxt;
    bcd_r        <= bcd_nxt;
    mag_r        <= mag_nxt;
    status_r     <= status_nxt;
    cm_r         <= cm_nxt;
    ce_r         <= ce_nxt;
    um_r         <= um_nxt;
    ue_r         <= ue_nxt;
    out_status_r <= out_status_nxt;
    out_cm_r     <= out_cm_nxt;
    out_ce_r     <= out_ce_nxt;
    out_um_r     <= out_um_nxt;
    out_ue_r     <= out_ue_nxt;
  end

  // One restoring divide step; the quotient bit drives the double-dabble shift.
  always_comb begin
    div_shift = {rem_r[CNT_W-1:0], num_sr_r[CNT_W-1]};
    div_diff  = div_shift - {1'b0, den_r};
    div_ge    = div_shift >= {1'b0, den_r};
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
    mant = MANT_W'(bcd_r[11:8]) * 10'd100 + MANT_W'(bcd_r[7:4]) * 10'd10
         + MANT_W'(bcd_r[3:0]);
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    sel_nxt    = sel_r;
    tick_nxt   = tick_r;
    ucw_nxt    = ucw_r;
    ccw_nxt    = ccw_r;
    gcw_nxt    = gcw_r;
    p_sr_nxt   = p_sr_r;
    kc_sr_nxt  = kc_sr_r;
    ku_sr_nxt  = ku_sr_r;
    t_nxt      = t_r;
    zero_nxt   = zero_r;
    acc_c_nxt  = acc_c_r;
    acc_u_nxt  = acc_u_r;
    den_nxt    = den_r;
    num_sr_nxt = num_sr_r;
    rem_nxt    = rem_r;
    bcd_nxt    = bcd_r;
    mag_nxt    = mag_r;
    status_nxt = status_r;
    cm_nxt     = cm_r;
    ce_nxt     = ce_r;
    um_nxt     = um_r;
    ue_nxt     = ue_r;

    out_valid_nxt  = out_valid_r & ~out_ready;
    out_status_nxt = out_status_r;
    out_cm_nxt     = out_cm_r;
    out_ce_nxt     = out_ce_r;
    out_um_nxt     = out_um_r;
    out_ue_nxt     = out_ue_r;

    in_ready = (state_r == S_IDLE);

    if (cfg_wr_en) begin
      tick_nxt = cfg_wr_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ucw_nxt   = in_uncorrectable_count;
          ccw_nxt   = in_corrected_count;
          gcw_nxt   = in_good_count;
          p_sr_nxt  = MUL_STEPS'(in_period_length);
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        t_nxt     = ccw_r + gcw_r * CW_BITS;
        zero_nxt  = (ccw_r + gcw_r) == '0;
        kc_sr_nxt = MUL_STEPS'(KC_W'(tick_r) * CCW_MULT);
        ku_sr_nxt = MUL_STEPS'(KU_W'(tick_r) * UCW_MULT);
        acc_c_nxt = '0;
        acc_u_nxt = '0;
        den_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        // Horner: acc = 2*acc + bit * operand, scale constant or period fed MSB first
        acc_c_nxt = {acc_c_r[ACC_C_W-2:0], 1'b0}
                  + (kc_sr_r[MUL_STEPS-1] ? ACC_C_W'(ccw_r) : '0);
        acc_u_nxt = {acc_u_r[ACC_U_W-2:0], 1'b0}
                  + (ku_sr_r[MUL_STEPS-1] ? ACC_U_W'(ucw_r) : '0);
        den_nxt   = {den_r[CNT_W-2:0], 1'b0} + (p_sr_r[MUL_STEPS-1] ? t_r : '0);
        kc_sr_nxt = {kc_sr_r[MUL_STEPS-2:0], 1'b0};
        ku_sr_nxt = {ku_sr_r[MUL_STEPS-2:0], 1'b0};
        p_sr_nxt  = {p_sr_r[MUL_STEPS-2:0], 1'b0};
        if (cnt_r == 6'(MUL_STEPS - 1)) begin
          state_nxt = S_CHECK;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_CHECK: begin
        // count > limit is the same as the unwrapped numerator leaving 64 bits
        priority if (zero_r) begin
          status_nxt = ST_ZERO_TOTAL;
        end else if (acc_c_r[ACC_C_W-1:CNT_W] != '0) begin
          status_nxt = ST_CCW_OVF;
        end else if (acc_u_r[ACC_U_W-1:CNT_W] != '0) begin
          status_nxt = ST_UCW_OVF;
        end else if (den_r == '0) begin
          status_nxt = ST_ZERO_DIV;
        end else begin
          status_nxt = ST_OK;
        end
        if (status_nxt != ST_OK) begin
          cm_nxt    = '0;
          ce_nxt    = '0;
          um_nxt    = '0;
          ue_nxt    = '0;
          state_nxt = S_DONE;
        end else begin
          num_sr_nxt = acc_c_r[CNT_W-1:0];
          rem_nxt    = '0;
          bcd_nxt    = '0;
          mag_nxt    = '0;
          cnt_nxt    = '0;
          sel_nxt    = 1'b0;
          state_nxt  = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt    = div_ge ? div_diff : div_shift;
        num_sr_nxt = {num_sr_r[CNT_W-2:0], 1'b0};
        bcd_nxt    = {bcd_adj[BCD_W-2:0], div_ge};
        if (cnt_r == 6'(DIV_STEPS - 1)) begin
          state_nxt = S_NORM;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_NORM: begin
        // drop two decimal digits while four or more remain
        if (bcd_r[BCD_W-1:12] != '0) begin
          bcd_nxt = {8'b0, bcd_r[BCD_W-1:8]};
          mag_nxt = mag_r + 5'd2;
        end else if (!sel_r) begin
          cm_nxt     = mant;
          ce_nxt     = mag_r - CCW_EXP;
          num_sr_nxt = acc_u_r[CNT_W-1:0];
          rem_nxt    = '0;
          bcd_nxt    = '0;
          mag_nxt    = '0;
          cnt_nxt    = '0;
          sel_nxt    = 1'b1;
          state_nxt  = S_DIV;
        end else begin
          um_nxt    = mant;
          ue_nxt    = mag_r - UCW_EXP;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_cm_nxt     = cm_r;
          out_ce_nxt     = ce_r;
          out_um_nxt     = um_r;
          out_ue_nxt     = ue_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid                  = out_valid_r;
  assign out_status                 = out_status_r;
  assign out_corrected_mantissa     = out_cm_r;
  assign out_corrected_exponent     = out_ce_r;
  assign out_uncorrectable_mantissa = out_um_r;
  assign out_uncorrectable_exponent = out_ue_r;

endmodule

[tb/fec_ber_estimate_tb.sv]
// Self-checking testbench for the FEC codeword error rate estimator.
`timescale 1ns / 1ps

module fec_ber_estimate_tb;
  import fbe_pkg::*;

  // ---------------------------------------------------------------------------
  // Bench constants
  // ---------------------------------------------------------------------------
  localparam int          HALF_PERIOD  = 10;
  localparam int          RESET_CYCLES = 4;
  localparam int          RUN_LIMIT    = 2000000;  // watchdog limit on the whole run
  localparam int          DRAIN_CYCLES = 250;      // longer than the worst word latency
  localparam int          RANDOM_BATCH = 90;       // random words per tick setting

  localparam logic [63:0] U64_MAX       = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] CODEWORD_BITS = 64'd5440;
  localparam logic [63:0] PER_MILLION   = 64'd1000000;
  localparam logic [63:0] PER_TRILLION  = 64'd1000000000000;
  localparam int          CCW_SHIFT     = 6;       // corrected rate is per 10^6
  localparam int          UCW_SHIFT     = 12;      // uncorrectable rate is per 10^12

  // One input word: the counters of a measurement period.
  typedef struct packed {
    logic [CNT_W-1:0] ucw;
    logic [CNT_W-1:0] ccw;
    logic [CNT_W-1:0] gcw;
    logic [PER_W-1:0] period;
  } cw_word_t;

  // One result word; exponents kept as raw 5-bit two's complement.
  typedef struct packed {
    status_t           status;
    logic [MANT_W-1:0] c_mant;
    logic [EXP_W-1:0]  c_exp;
    logic [MANT_W-1:0] u_mant;
    logic [EXP_W-1:0]  u_exp;
  } rate_t;

  // Receiver pacing styles.
  typedef enum logic [1:0] {
    PACE_OPEN,    // always ready
    PACE_COIN,    // ready half the time
    PACE_SPARSE,  // ready one cycle in eight, long stalls
    PACE_COMB     // fixed comb pattern keyed to the cycle counter
  } pace_t;

  // ---------------------------------------------------------------------------
  // DUT signals, all inputs known from time zero
  // ---------------------------------------------------------------------------
  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_wr_en = 1'b0;
  logic [TICK_W-1:0]       cfg_wr_data = TICK_RESET;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [CNT_W-1:0]        in_uncorrectable_count = '0;
  logic [CNT_W-1:0]        in_corrected_count = '0;
  logic [CNT_W-1:0]        in_good_count = '0;
  logic [PER_W-1:0]        in_period_length = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [STAT_W-1:0]       out_status;
  logic [MANT_W-1:0]       out_corrected_mantissa;
  logic signed [EXP_W-1:0] out_corrected_exponent;
  logic [MANT_W-1:0]       out_uncorrectable_mantissa;
  logic signed [EXP_W-1:0] out_uncorrectable_exponent;

  // ---------------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------------
  cw_word_t          word_backlog[$];   // words waiting to be offered
  rate_t             owed_rates[$];     // predicted results, oldest first
  logic [TICK_W-1:0] tick_model = TICK_RESET;  // bench copy of the tick register
  cw_word_t          cur_word;          // word currently on the input port
  int                mismatches = 0;
  int                cycle_count = 0;
  int                burst_left = 0;
  int                gap_left = 0;
  pace_t             pace_mode = PACE_OPEN;
  int                pace_left = 0;

  fec_ber_estimate dut (
    .clk                        (clk),
    .rst_n                      (rst_n),
    .cfg_wr_en                  (cfg_wr_en),
    .cfg_wr_data                (cfg_wr_data),
    .in_valid                   (in_valid),
    .in_ready                   (in_ready),
    .in_uncorrectable_count     (in_uncorrectable_count),
    .in_corrected_count         (in_corrected_count),
    .in_good_count              (in_good_count),
    .in_period_length           (in_period_length),
    .out_valid                  (out_valid),
    .out_ready                  (out_ready),
    .out_status                 (out_status),
    .out_corrected_mantissa     (out_corrected_mantissa),
    .out_corrected_exponent     (out_corrected_exponent),
    .out_uncorrectable_mantissa (out_uncorrectable_mantissa),
    .out_uncorrectable_exponent (out_uncorrectable_exponent)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Largest count whose scaled product still fits in 64 bits. A tick of zero
  // makes the scale zero, which means no count is ever too large.
  function automatic logic [63:0] overflow_limit(input logic [TICK_W-1:0] tk,
                                                 input logic [63:0] mult);
    logic [63:0] scale;
    scale = {54'd0, tk} * mult;
    if (scale == 64'd0)
      return U64_MAX;
    return U64_MAX / scale;
  endfunction

  // Strip pairs of decimal digits until at most three remain; each pair adds 2 to
  // the exponent, then the per-million / per-trillion offset comes off.
  function automatic void to_decimal(input logic [63:0] rate, input int offset,
                                     output logic [MANT_W-1:0] mant,
                                     output logic [EXP_W-1:0] expo);
    logic [63:0] r;
    int          mag;
    int          e;
    r   = rate;
    mag = 0;
    while (r >= 64'd1000) begin
      r   = r / 64'd100;
      mag = mag + 2;
    end
    e    = mag - offset;
    mant = r[MANT_W-1:0];
    expo = e[EXP_W-1:0];
  endfunction

  // Full result for one word under a given tick rate. Every product wraps
  // at 64 bits, the denominator included.
  function automatic rate_t estimate_rates(input cw_word_t w, input logic [TICK_W-1:0] tk);
    rate_t       r;
    logic [63:0] tk64;
    logic [63:0] denom;
    logic [63:0] total;
    tk64   = {54'd0, tk};
    r      = '0;
    r.status = ST_OK;
    total  = w.ccw + w.gcw;
    denom  = (w.ccw + w.gcw * CODEWORD_BITS) * {32'd0, w.period};
    if (total == 64'd0)
      r.status = ST_ZERO_TOTAL;
    else if (w.ccw > overflow_limit(tk, PER_MILLION))
      r.status = ST_CCW_OVF;
    else if (w.ucw > overflow_limit(tk, PER_TRILLION))
      r.status = ST_UCW_OVF;
    else if (denom == 64'd0)
      r.status = ST_ZERO_DIV;
    else begin
      to_decimal((w.ccw * tk64 * PER_MILLION) / denom, CCW_SHIFT, r.c_mant, r.c_exp);
      to_decimal((w.ucw * tk64 * PER_TRILLION) / denom, UCW_SHIFT, r.u_mant, r.u_exp);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] any_u64();
    return {$urandom, $urandom};
  endfunction

  // Random magnitude: a full random value shifted down by a random amount,
  // so small, medium and huge counts all show up.
  function automatic logic [63:0] some_u64();
    return any_u64() >> $urandom_range(0, 63);
  endfunction

  task automatic push_word(input logic [63:0] u, input logic [63:0] c,
                           input logic [63:0] g, input logic [31:0] p);
    cw_word_t w;
    w.ucw    = u;
    w.ccw    = c;
    w.gcw    = g;
    w.period = p;
    word_backlog.push_back(w);
  endtask

  // Hand-picked corners for the current tick: each error status, the check
  // priority, wrapped totals and denominators, and the 999/1000 step of the
  // mantissa scaler.
  task automatic queue_directed(input logic [TICK_W-1:0] tk);
    logic [63:0] c_lim;
    logic [63:0] u_lim;
    logic [31:0] p_knee;
    c_lim  = overflow_limit(tk, PER_MILLION);
    u_lim  = overflow_limit(tk, PER_TRILLION);
    p_knee = {22'd0, tk} * 32'd1000;   // with 1000 corrected, 1 uncorrectable: corrected rate 1000
    push_word(64'd0, 64'd0, 64'd0, 32'd0);                 // zero total
    push_word(64'd0, 64'd1, U64_MAX, 32'd5);               // total wraps to zero
    push_word(64'd0, c_lim, 64'd0, 32'd1);                 // corrected at its limit
    push_word(64'd0, c_lim + 64'd1, 64'd0, 32'd1);         // corrected one past
    push_word(u_lim, 64'd1, 64'd0, 32'd1);                 // uncorrectable at limit, top exp
    push_word(u_lim + 64'd1, 64'd1, 64'd0, 32'd1);         // uncorrectable one past
    push_word(u_lim + 64'd1, c_lim + 64'd1, 64'd7, 32'd9); // corrected check wins
    push_word(64'd1, 64'd1, 64'd0, 32'd0);                 // zero period
    push_word(64'd0, 64'd0, 64'd1 << 58, 32'hFFFF_FFFF);   // good*5440 wraps to zero
    push_word(64'd5, 64'd0, 64'd1 << 40, 32'd1 << 26);     // product wraps to zero
    push_word(64'd1, 64'd1000, 64'd0, p_knee);             // corrected rate exactly 1000
    push_word(64'd1, 64'd1000, 64'd0, p_knee + 32'd1);     // corrected rate just under 1000
    push_word(64'd0, 64'd0, 64'd1, 32'd1);                 // both rates zero
    push_word(U64_MAX, U64_MAX, U64_MAX, 32'hFFFF_FFFF);   // everything maxed
    push_word(64'd3, 64'd7, 64'd11, 32'hFFFF_FFFF);        // longest period
    push_word(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
              64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
    push_word(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
              64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
    push_word(64'd1000, 64'd999, 64'd12345, 32'd777);      // ordinary period
  endtask

  // Mostly counts inside the overflow limits so the divider and scaler get
  // real work; the rest hits limit edges, zero totals, zero divisors and
  // unrestricted noise.
  task automatic queue_random(input int count, input logic [TICK_W-1:0] tk);
    cw_word_t    w;
    logic [63:0] c_lim;
    logic [63:0] u_lim;
    int          pick;
    c_lim = overflow_limit(tk, PER_MILLION);
    u_lim = overflow_limit(tk, PER_TRILLION);
    repeat (count) begin
      pick     = $urandom_range(0, 99);
      w.ucw    = some_u64();
      w.ccw    = some_u64();
      w.gcw    = some_u64();
      w.period = $urandom >> $urandom_range(0, 31);
      if (pick < 72) begin
        if (c_lim != U64_MAX) w.ccw = w.ccw % (c_lim + 64'd1);
        if (u_lim != U64_MAX) w.ucw = w.ucw % (u_lim + 64'd1);
      end else if (pick < 84) begin
        // straddle the limits by one either way
        w.ccw = c_lim - 64'd1 + $urandom_range(0, 2);
        w.ucw = ($urandom_range(0, 1) == 1) ? u_lim - 64'd1 + $urandom_range(0, 2) : 64'd0;
        if (w.ccw > c_lim && $urandom_range(0, 1) == 1) w.ccw = c_lim;
      end else if (pick < 89) begin
        w.ccw = w.ccw % 64'd100000;
        w.gcw = -w.ccw;                     // total wraps to zero
      end else if (pick < 94) begin
        w.ccw = 64'd0;
        w.ucw = w.ucw % 64'd1000;
        if ($urandom_range(0, 1) == 1)
          w.period = 32'd0;
        else
          w.gcw = 64'd1 << $urandom_range(58, 63);
      end else begin
        w.ucw    = any_u64();
        w.ccw    = any_u64();
        w.gcw    = any_u64();
        w.period = $urandom;
      end
      word_backlog.push_back(w);
    end
  endtask

  // Block until every queued word is taken and every result is back.
  // Sampled on the falling edge so rising-edge updates have all landed.
  task automatic settle();
    while (word_backlog.size() != 0 || in_valid || owed_rates.size() != 0)
      @(negedge clk);
  endtask

  // Single-cycle register write, only ever issued while the block is idle.
  task automatic program_tick(input logic [TICK_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tick_model   = v;
  endtask

  task automatic flag_field(input string label, input logic signed [15:0] want_v,
                            input logic signed [15:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, label, want_v, got_v);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of back-to-back offers separated by random gaps. A word
  // is predicted at the edge that accepts it, using the tick in force then.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : word_driver
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && in_ready)
        owed_rates.push_back(estimate_rates(cur_word, tick_model));
      if (!in_valid || in_ready) begin
        if (burst_left != 0 && word_backlog.size() != 0) begin
          cur_word = word_backlog.pop_front();
          in_uncorrectable_count <= cur_word.ucw;
          in_corrected_count     <= cur_word.ccw;
          in_good_count          <= cur_word.gcw;
          in_period_length       <= cur_word.period;
          in_valid               <= 1'b1;
          burst_left             <= burst_left - 1;
        end else begin
          in_valid <= 1'b0;
          if (gap_left != 0)
            gap_left <= gap_left - 1;
          else begin
            // a quarter of the bursts come with no gap at all
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver pacing: switches style after a random number of cycles
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : sink_pacing
    if (!rst_n) begin
      out_ready <= 1'b0;
      pace_mode <= PACE_OPEN;
      pace_left <= 0;
    end else begin
      if (pace_left == 0) begin
        pace_mode <= pace_t'($urandom_range(0, 3));
        pace_left <= $urandom_range(100, 600);
      end else begin
        pace_left <= pace_left - 1;
      end
      case (pace_mode)
        PACE_OPEN:   out_ready <= 1'b1;
        PACE_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
        PACE_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
        default:     out_ready <= (cycle_count % 8 != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result word against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    rate_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_rates.size() == 0) begin
        $display("%0t ns: unexpected result word, expected none actual status %0d",
                 $time, out_status);
        mismatches++;
      end else begin
        want = owed_rates.pop_front();
        flag_field("status", {13'd0, want.status}, {13'd0, out_status});
        flag_field("corrected mantissa", {6'd0, want.c_mant}, {6'd0, out_corrected_mantissa});
        flag_field("corrected exponent", $signed(want.c_exp), out_corrected_exponent);
        flag_field("uncorrectable mantissa", {6'd0, want.u_mant},
                   {6'd0, out_uncorrectable_mantissa});
        flag_field("uncorrectable exponent", $signed(want.u_exp), out_uncorrectable_exponent);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    wait (cycle_count >= RUN_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence. Each tick setting runs a batch and then drains completely,
  // so the sender sits idle until every owed result has come back before the
  // register changes. The first batch also drains halfway through.
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    logic [TICK_W-1:0] tick_plan[$];
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset value of the tick register first
    queue_directed(tick_model);
    queue_random(RANDOM_BATCH / 2, tick_model);
    settle();
    queue_random(RANDOM_BATCH / 2, tick_model);
    settle();

    // smallest, nominal largest, all ones, zero, then two random settings
    tick_plan = '{10'd1, 10'd1000, 10'd1023, 10'd0};
    tick_plan.push_back($urandom_range(1, 1000));
    tick_plan.push_back($urandom_range(1, 1000));
    foreach (tick_plan[i]) begin
      program_tick(tick_plan[i]);
      queue_random(RANDOM_BATCH, tick_model);
      settle();
    end

    // catch any stray result words
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
design/fbe_pkg.sv
design/fec_ber_estimate.sv
tb/fec_ber_estimate_tb.sv
